// ===== sv/itc_pkg.sv =====
// Package with the shared types and codes of the interval timer channel.
`timescale 1ns / 1ps

package itc_pkg;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [1:0] PORT_DATA = 2'd0;
    localparam logic [1:0] PORT_CTRL = 2'd3;

    localparam logic [1:0] TGT_CNT0     = 2'b00;
    localparam logic [1:0] TGT_READBACK = 2'b11;

    localparam logic [1:0] RW_LATCH = 2'b00;

    localparam int OUT_DEPTH = 3;

    typedef struct packed {
        logic [1:0] operation;
        logic [1:0] port;
        logic [7:0] write_data;
    } t_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       out_level;
        logic       irq_edge;
    } t_result;

    typedef struct packed {
        logic        rate_mode;
        logic [15:0] initial_count;
        logic [15:0] count_now;
        logic [7:0]  low_byte_hold;
        logic        write_high_next;
        logic        read_high_next;
        logic        load_pending;
        logic        counting;
        logic        out_pin;
        logic [15:0] latched_count;
        logic        latch_valid;
    } t_state;

endpackage

// ===== sv/itc_ifs.sv =====
// Valid/ready channel interfaces for the timer's input and result words.
`timescale 1ns / 1ps

interface itc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [1:0] port;
    logic [7:0] write_data;

    modport source (output valid, output operation, output port, output write_data,
                    input ready);
    modport sink (input valid, input operation, input port, input write_data,
                  output ready);
endinterface

interface itc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       out_level;
    logic       irq_edge;

    modport source (output valid, output read_data, output out_level, output irq_edge,
                    input ready);
    modport sink (input valid, input read_data, input out_level, input irq_edge,
                  output ready);
endinterface

// ===== sv/itc_step.sv =====
// Next-state and result logic of counter 0 for one input word.
`timescale 1ns / 1ps

module itc_step
    import itc_pkg::*;
(
    input  t_item   i_item,
    input  t_state  i_state,
    output t_state  o_state,
    output t_result o_result
);

    t_state      s;
    logic [7:0]  rd;
    logic [15:0] dec;
    logic [15:0] rd_src;

    assign dec    = i_state.count_now - 16'd1;
    assign rd_src = i_state.latch_valid ? i_state.latched_count : i_state.count_now;

    always_comb begin
        s  = i_state;
        rd = 8'd0;
        unique case (i_item.operation)
            OP_WRITE: begin
                if (i_item.port == PORT_CTRL) begin
                    if (i_item.write_data[7:6] == TGT_CNT0) begin
                        if (i_item.write_data[5:4] == RW_LATCH) begin
                            if (!i_state.latch_valid) begin
                                s.latched_count = i_state.count_now;
                                s.latch_valid   = 1'b1;
                            end
                        end else begin
                            s.rate_mode       = i_item.write_data[2];
                            s.counting        = 1'b0;
                            s.load_pending    = 1'b0;
                            s.write_high_next = 1'b0;
                            s.read_high_next  = 1'b0;
                            s.latch_valid     = 1'b0;
                            s.out_pin         = i_item.write_data[2];
                        end
                    end else if (i_item.write_data[7:6] == TGT_READBACK) begin
                        if (!i_item.write_data[5] && i_item.write_data[1] &&
                            !i_state.latch_valid) begin
                            s.latched_count = i_state.count_now;
                            s.latch_valid   = 1'b1;
                        end
                    end
                end else if (i_item.port == PORT_DATA) begin
                    if (!i_state.write_high_next) begin
                        s.low_byte_hold   = i_item.write_data;
                        s.write_high_next = 1'b1;
                        if (!i_state.rate_mode) begin
                            s.counting = 1'b0;
                            s.out_pin  = 1'b0;
                        end
                    end else begin
                        s.initial_count   = {i_item.write_data, i_state.low_byte_hold};
                        s.write_high_next = 1'b0;
                        s.load_pending    = 1'b1;
                        if (!i_state.rate_mode) begin
                            s.out_pin = 1'b0;
                        end
                    end
                end
            end
            OP_READ: begin
                if (i_item.port == PORT_DATA) begin
                    if (!i_state.read_high_next) begin
                        rd               = rd_src[7:0];
                        s.read_high_next = 1'b1;
                    end else begin
                        rd               = rd_src[15:8];
                        s.read_high_next = 1'b0;
                        s.latch_valid    = 1'b0;
                    end
                end
            end
            OP_TICK: begin
                if (i_state.load_pending && (!i_state.counting || !i_state.rate_mode)) begin
                    s.count_now    = i_state.initial_count;
                    s.counting     = 1'b1;
                    s.load_pending = 1'b0;
                    if (i_state.rate_mode) begin
                        s.out_pin = 1'b1;
                    end
                end else if (i_state.counting) begin
                    if (i_state.rate_mode) begin
                        if (i_state.count_now == 16'd1) begin
                            s.count_now    = i_state.initial_count;
                            s.load_pending = 1'b0;
                            s.out_pin      = 1'b1;
                        end else begin
                            s.count_now = dec;
                            if (dec == 16'd1) begin
                                s.out_pin = 1'b0;
                            end
                        end
                    end else begin
                        s.count_now = dec;
                        if (dec == 16'd0) begin
                            s.out_pin = 1'b1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_state            = s;
    assign o_result.read_data = rd;
    assign o_result.out_level = s.out_pin;
    assign o_result.irq_edge  = !i_state.out_pin && s.out_pin;

endmodule

// ===== sv/itc_out_fifo.sv =====
// Small result queue that decouples the timer from a stalling receiver.
`timescale 1ns / 1ps

module itc_out_fifo
    import itc_pkg::*;
#(
    parameter int DEPTH = OUT_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  t_result                    i_push_data,
    input  logic                       i_pop,
    output logic                       o_valid,
    output t_result                    o_data,
    output logic [$clog2(DEPTH+1)-1:0] o_level
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_result       r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          do_pop;

    assign do_pop = i_pop && (r_count != '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (i_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && do_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_level = r_count;

endmodule

// ===== sv/interval_timer_channel_core.sv =====
// Top level of counter 0 of the interval timer.
//
// The input channel carries one word per bus write, bus read or timer input
// clock tick. The output channel returns exactly one result word for each
// input word, in order: the read byte, the OUT pin level and the interrupt
// edge flag.
// An accepted word is held in an input register, the counter state and the
// result are computed from it combinationally, and the result enters a
// three-entry output queue. A result is visible once its word has passed
// the input register and the result has been written into the queue.
// The block takes one word per cycle for as long as the receiver keeps
// taking results. Ready is derived combinationally from the registered queue
// occupancy and input register, so the input side keeps accepting while results
// are still waiting; a stalled receiver lets the queue fill, and ready falls
// only when the input register and the queue together hold three words.
// Synchronous active-low reset clears the counter state to one-shot mode
// with the counter stopped and OUT low, and empties the input register and
// the queue.
`timescale 1ns / 1ps

module interval_timer_channel_core
    import itc_pkg::*;
#(
    parameter int OUT_Q_DEPTH = OUT_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    itc_in_if.sink       i_in,
    itc_out_if.source    o_out
);

    localparam int LW = $clog2(OUT_Q_DEPTH + 1);

    logic          r_in_valid;
    t_item         r_in_item;
    t_state        r_state, n_state;
    t_result       step_result;
    t_result       q_data;
    logic          q_valid;
    logic [LW-1:0] q_level;
    logic [LW:0]   in_flight;
    logic          accept;

    assign in_flight  = {1'b0, q_level} + (LW + 1)'(r_in_valid);
    assign i_in.ready = (in_flight < (LW + 1)'(OUT_Q_DEPTH));
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_item.operation  <= i_in.operation;
            r_in_item.port       <= i_in.port;
            r_in_item.write_data <= i_in.write_data;
        end
    end

    itc_step u_step (
        .i_item   (r_in_item),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (r_in_valid) begin
            r_state <= n_state;
        end
    end

    itc_out_fifo #(
        .DEPTH (OUT_Q_DEPTH)
    ) u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (r_in_valid),
        .i_push_data (step_result),
        .i_pop       (o_out.ready),
        .o_valid     (q_valid),
        .o_data      (q_data),
        .o_level     (q_level)
    );

    assign o_out.valid     = q_valid;
    assign o_out.read_data = q_data.read_data;
    assign o_out.out_level = q_data.out_level;
    assign o_out.irq_edge  = q_data.irq_edge;

endmodule

// ===== sv/itc_checker.sv =====
// Port-level checker for the interval timer channel, bound to the top level.
`timescale 1ns / 1ps

module itc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_read_data,
    input logic       i_out_level,
    input logic       i_out_irq_edge
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_read_data) &&
            $stable(i_out_level) && $stable(i_out_irq_edge))
        else $error("Result word changed while stalled.");

    a_irq_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_irq_edge |-> i_out_level)
        else $error("Interrupt edge reported with OUT low.");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> ##1 i_out_valid)
        else $error("No result word two cycles after an accepted word.");

    a_full_has_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("Input stalled while no result word is pending.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("Result word present right after reset.");

endmodule

bind interval_timer_channel_core itc_checker u_itc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_read_data (o_out.read_data),
    .i_out_level     (o_out.out_level),
    .i_out_irq_edge  (o_out.irq_edge)
);

// ===== test/tb.sv =====
// Self-checking testbench for counter 0 of the interval timer.
`timescale 1ns / 1ps

module tb;
    import itc_pkg::*;

    localparam logic [1:0] OP_NOP      = 2'd3;
    localparam logic [1:0] PORT_SPARE1 = 2'd1;
    localparam logic [1:0] PORT_SPARE2 = 2'd2;

    localparam logic [7:0] CW_ONESHOT  = 8'h30;
    localparam logic [7:0] CW_RATE     = 8'h34;
    localparam logic [7:0] CW_LATCH    = 8'h00;
    localparam logic [7:0] CW_READBACK = 8'hD2;
    localparam logic [7:0] CW_COUNTER1 = 8'h40;
    localparam logic [7:0] CW_COUNTER2 = 8'h80;

    localparam int RANDOM_WORDS = 1925;
    localparam int IDLE_LIMIT   = 500;
    localparam int TAIL_CYCLES  = 10;

    typedef struct packed {
        logic  hold;
        t_item word;
    } t_bus_op;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    itc_in_if  in_ch ();
    itc_out_if out_ch ();

    interval_timer_channel_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #6 i_clk = ~i_clk;

    t_state  tmr;
    t_bus_op bus_ops[$];
    t_result timer_results[$];

    bit hold_next = 1'b0;
    int word_count = 0;
    int mismatches = 0;
    int idle_cycles = 0;

    bit in_fire = 1'b0;
    bit out_fire = 1'b0;
    bit in_busy = 1'b0;
    int in_gap = 0;
    int in_calm = 0;
    int out_stall = 0;
    int out_calm = 0;

    function automatic void freeze_count();
        if (!tmr.latch_valid) begin
            tmr.latched_count = tmr.count_now;
            tmr.latch_valid = 1'b1;
        end
    endfunction

    function automatic t_result timer_step(t_item it);
        t_result     r;
        logic        was_high;
        logic [15:0] v;
        r = '0;
        was_high = tmr.out_pin;
        case (it.operation)
            OP_WRITE: begin
                if (it.port == PORT_CTRL) begin
                    if (it.write_data[7:6] == TGT_CNT0) begin
                        if (it.write_data[5:4] == RW_LATCH) begin
                            freeze_count();
                        end else begin
                            tmr.rate_mode = it.write_data[2];
                            tmr.counting = 1'b0;
                            tmr.load_pending = 1'b0;
                            tmr.write_high_next = 1'b0;
                            tmr.read_high_next = 1'b0;
                            tmr.latch_valid = 1'b0;
                            tmr.out_pin = tmr.rate_mode;
                        end
                    end else if (it.write_data[7:6] == TGT_READBACK) begin
                        if (!it.write_data[5] && it.write_data[1]) freeze_count();
                    end
                end else if (it.port == PORT_DATA) begin
                    if (!tmr.write_high_next) begin
                        tmr.low_byte_hold = it.write_data;
                        tmr.write_high_next = 1'b1;
                        if (!tmr.rate_mode) begin
                            tmr.counting = 1'b0;
                            tmr.out_pin = 1'b0;
                        end
                    end else begin
                        tmr.initial_count = {it.write_data, tmr.low_byte_hold};
                        tmr.write_high_next = 1'b0;
                        tmr.load_pending = 1'b1;
                        if (!tmr.rate_mode) tmr.out_pin = 1'b0;
                    end
                end
            end
            OP_READ: begin
                if (it.port == PORT_DATA) begin
                    v = tmr.latch_valid ? tmr.latched_count : tmr.count_now;
                    if (!tmr.read_high_next) begin
                        r.read_data = v[7:0];
                        tmr.read_high_next = 1'b1;
                    end else begin
                        r.read_data = v[15:8];
                        tmr.read_high_next = 1'b0;
                        tmr.latch_valid = 1'b0;
                    end
                end
            end
            OP_TICK: begin
                if (tmr.load_pending && (!tmr.counting || !tmr.rate_mode)) begin
                    tmr.count_now = tmr.initial_count;
                    tmr.counting = 1'b1;
                    tmr.load_pending = 1'b0;
                    if (tmr.rate_mode) tmr.out_pin = 1'b1;
                end else if (tmr.counting) begin
                    if (tmr.rate_mode) begin
                        if (tmr.count_now == 16'd1) begin
                            tmr.count_now = tmr.initial_count;
                            tmr.load_pending = 1'b0;
                            tmr.out_pin = 1'b1;
                        end else begin
                            tmr.count_now = tmr.count_now - 16'd1;
                            if (tmr.count_now == 16'd1) tmr.out_pin = 1'b0;
                        end
                    end else begin
                        tmr.count_now = tmr.count_now - 16'd1;
                        if (tmr.count_now == 16'd0) tmr.out_pin = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        r.out_level = tmr.out_pin;
        r.irq_edge = !was_high && tmr.out_pin;
        return r;
    endfunction

    task automatic queue_word(input logic [1:0] op, input logic [1:0] prt,
                              input logic [7:0] data);
        t_bus_op b;
        b.hold = hold_next;
        b.word.operation = op;
        b.word.port = prt;
        b.word.write_data = data;
        hold_next = 1'b0;
        bus_ops.push_back(b);
        if (op != OP_NOP) word_count++;
    endtask

    task automatic queue_ticks(input int n);
        repeat (n) queue_word(OP_TICK, PORT_DATA, 8'($urandom_range(0, 255)));
    endtask

    task automatic queue_reads(input int n);
        repeat (n) queue_word(OP_READ, PORT_DATA, 8'($urandom_range(0, 255)));
    endtask

    // Input driver.
    always @(negedge i_clk) begin
        t_bus_op nxt;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_fire) begin
                in_busy = 1'b0;
                if (in_calm > 0) begin
                    in_calm--;
                    in_gap = 0;
                end else begin
                    if ($urandom_range(0, 15) == 0) in_calm = $urandom_range(10, 40);
                    in_gap = $urandom_range(0, 5);
                end
            end
            if (!in_busy) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (bus_ops.size() > 0 &&
                             !(bus_ops[0].hold && timer_results.size() > 0)) begin
                    nxt = bus_ops.pop_front();
                    in_ch.operation <= nxt.word.operation;
                    in_ch.port <= nxt.word.port;
                    in_ch.write_data <= nxt.word.write_data;
                    in_busy = 1'b1;
                end
            end
            in_ch.valid <= in_busy;
        end
    end

    // Result receiver.
    always @(negedge i_clk) begin
        bit rdy;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_fire) begin
                if (out_calm > 0) begin
                    out_calm--;
                    out_stall = 0;
                end else begin
                    if ($urandom_range(0, 15) == 0) out_calm = $urandom_range(10, 40);
                    out_stall = $urandom_range(0, 5);
                end
            end
            rdy = (out_stall == 0);
            if (out_stall > 0) out_stall--;
            out_ch.ready <= rdy;
        end
    end

    // Monitor, checker and watchdog.
    always @(posedge i_clk) begin
        t_item   it;
        t_result got;
        t_result want;
        in_fire = 1'b0;
        out_fire = 1'b0;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                in_fire = 1'b1;
                it.operation = in_ch.operation;
                it.port = in_ch.port;
                it.write_data = in_ch.write_data;
                timer_results.push_back(timer_step(it));
            end
            if (out_ch.valid && out_ch.ready) begin
                out_fire = 1'b1;
                got.read_data = out_ch.read_data;
                got.out_level = out_ch.out_level;
                got.irq_edge = out_ch.irq_edge;
                if (timer_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result word: rd=%02h out=%0b irq=%0b",
                                 got.read_data, got.out_level, got.irq_edge);
                end else begin
                    want = timer_results.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display(
                                "Mismatch: expected rd=%02h out=%0b irq=%0b, %s",
                                want.read_data, want.out_level, want.irq_edge,
                                $sformatf("got rd=%02h out=%0b irq=%0b",
                                          got.read_data, got.out_level, got.irq_edge));
                    end
                end
            end
            if (in_fire || out_fire) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        logic [7:0]  cw;
        logic [1:0]  rw;
        logic [2:0]  mode;
        logic [15:0] cnt;
        int          pick;
        int          next_hold;

        in_ch.valid = 1'b0;
        in_ch.operation = OP_WRITE;
        in_ch.port = PORT_DATA;
        in_ch.write_data = 8'h00;
        out_ch.ready = 1'b0;
        tmr = '0;

        // One-shot with a short count, run past terminal count and read back.
        queue_word(OP_WRITE, PORT_CTRL, CW_ONESHOT);
        queue_word(OP_WRITE, PORT_DATA, 8'h03);
        queue_word(OP_WRITE, PORT_DATA, 8'h00);
        queue_ticks(5);
        queue_reads(2);
        // Rate generator with a count of two, through one reload.
        queue_word(OP_WRITE, PORT_CTRL, CW_RATE);
        queue_word(OP_WRITE, PORT_DATA, 8'h02);
        queue_word(OP_WRITE, PORT_DATA, 8'h00);
        queue_ticks(4);
        // Counter latch, then a repeated latch by read-back, then a full read.
        queue_word(OP_WRITE, PORT_CTRL, CW_LATCH);
        queue_ticks(1);
        queue_word(OP_WRITE, PORT_CTRL, CW_READBACK);
        queue_reads(2);
        // Ignored targets, unused ports and the spare operation code.
        queue_word(OP_WRITE, PORT_CTRL, CW_COUNTER1);
        queue_word(OP_WRITE, PORT_CTRL, CW_COUNTER2);
        queue_word(OP_WRITE, PORT_SPARE1, 8'hFF);
        queue_word(OP_READ, PORT_CTRL, 8'hFF);
        queue_word(OP_NOP, PORT_SPARE2, 8'hFF);
        // A count of zero stands for the full range.
        queue_word(OP_WRITE, PORT_CTRL, CW_ONESHOT);
        queue_word(OP_WRITE, PORT_DATA, 8'h00);
        queue_word(OP_WRITE, PORT_DATA, 8'h00);
        queue_ticks(2);
        queue_reads(2);

        hold_next = 1'b1;
        next_hold = word_count + 600;
        while (word_count < RANDOM_WORDS) begin
            if (word_count >= next_hold) begin
                hold_next = 1'b1;
                next_hold += 600;
            end
            pick = $urandom_range(0, 99);
            if (pick < 22) begin
                rw = 2'($urandom_range(1, 3));
                case ($urandom_range(0, 3))
                    0: mode = 3'b000;
                    1: mode = 3'b010;
                    default: mode = 3'($urandom_range(0, 7));
                endcase
                cw = {TGT_CNT0, rw, mode, 1'($urandom_range(0, 1))};
                case ($urandom_range(0, 9))
                    6: cnt = 16'd0;
                    7: cnt = 16'd1;
                    8, 9: cnt = 16'($urandom_range(0, 65535));
                    default: cnt = 16'($urandom_range(1, 6));
                endcase
                queue_word(OP_WRITE, PORT_CTRL, cw);
                queue_word(OP_WRITE, PORT_DATA, cnt[7:0]);
                queue_word(OP_WRITE, PORT_DATA, cnt[15:8]);
                queue_ticks($urandom_range(1, 12));
            end else if (pick < 42) begin
                queue_ticks($urandom_range(1, 12));
            end else if (pick < 57) begin
                cw = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 1) == 0) begin
                    cw[7:6] = TGT_CNT0;
                    cw[5:4] = RW_LATCH;
                end else begin
                    cw[7:6] = TGT_READBACK;
                    cw[5] = 1'b0;
                    cw[1] = 1'b1;
                end
                queue_word(OP_WRITE, PORT_CTRL, cw);
                if ($urandom_range(0, 3) == 0) queue_ticks($urandom_range(1, 3));
                queue_reads($urandom_range(1, 3));
            end else if (pick < 70) begin
                queue_reads($urandom_range(1, 3));
            end else if (pick < 80) begin
                repeat ($urandom_range(1, 2))
                    queue_word(OP_WRITE, PORT_DATA, 8'($urandom_range(0, 255)));
                queue_ticks($urandom_range(0, 4));
            end else if (pick < 85) begin
                queue_word(OP_WRITE, PORT_CTRL, CW_LATCH);
                queue_ticks($urandom_range(1, 3));
                queue_word(OP_WRITE, PORT_CTRL, CW_READBACK);
                queue_reads(2);
            end else begin
                repeat ($urandom_range(1, 4))
                    queue_word(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                               8'($urandom_range(0, 255)));
            end
        end

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (bus_ops.size() == 0 && !in_busy && timer_results.size() == 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && timer_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
